/* hdl/cfb_pkg.sv */
// ----------------------------------------------------------------------------
// cfb_pkg: shared types and constants of the command frame builder
// Frame layout constants, request and control structs, and the CRC-8 byte
// update (MSB first, polynomial 0x31).
// ----------------------------------------------------------------------------
`default_nettype none

package cfb_pkg;

   localparam int MAX_PAYLOAD = 8;
   localparam int PAYLOAD_W   = 64;
   localparam int LEN_W       = 4;
   localparam int HDR_BYTES   = 5;              // prefix, sync, length, axis, command
   localparam int FRAME_MAX   = HDR_BYTES + MAX_PAYLOAD + 1;
   localparam int POS_W       = $clog2(FRAME_MAX);

   localparam logic [7:0] FRAME_PREFIX = 8'h06;
   localparam logic [7:0] FRAME_SYNC   = 8'hAA;
   localparam logic [7:0] CRC_POLY     = 8'h31;
   localparam logic [7:0] CRC_TOP      = 8'h80;
   localparam logic [7:0] LEN_OVERHEAD = 8'd2;

   localparam logic [POS_W-1:0] POS_PREFIX = POS_W'(0);
   localparam logic [POS_W-1:0] POS_SYNC   = POS_W'(1);
   localparam logic [POS_W-1:0] POS_LEN    = POS_W'(2);
   localparam logic [POS_W-1:0] POS_AXIS   = POS_W'(3);
   localparam logic [POS_W-1:0] POS_CMD    = POS_W'(4);

   typedef enum logic {
      SEQ_IDLE,
      SEQ_SEND
   } seq_state_type;

   typedef struct packed {
      logic [7:0]           axis;
      logic [7:0]           command;
      logic [LEN_W-1:0]     payload_len;
      logic [PAYLOAD_W-1:0] payload_bytes;
   } req_type;

   typedef struct packed {
      logic       clear;
      logic       update;
      logic [7:0] data;
   } crc_ctrl_type;

   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if ((c & CRC_TOP) != 8'd0) begin
            c = (c << 1) ^ CRC_POLY;
         end else begin
            c = c << 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

/* hdl/cfb_req_if.sv */
// ----------------------------------------------------------------------------
// cfb_req_if: command request channel
// Valid/ready channel carrying one command request per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface cfb_req_if
   import cfb_pkg::*;
   ;
   logic                 valid;
   logic                 ready;
   logic [7:0]           axis;
   logic [7:0]           command;
   logic [LEN_W-1:0]     payload_len;
   logic [PAYLOAD_W-1:0] payload_bytes;

   modport source (
      output valid, axis, command, payload_len, payload_bytes,
      input  ready
   );

   modport sink (
      input  valid, axis, command, payload_len, payload_bytes,
      output ready
   );
endinterface

`default_nettype wire

/* hdl/cfb_rsp_if.sv */
// ----------------------------------------------------------------------------
// cfb_rsp_if: frame byte channel
// Valid/ready channel carrying one frame byte per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface cfb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last;

   modport source (
      output valid, out_byte, last,
      input  ready
   );

   modport sink (
      input  valid, out_byte, last,
      output ready
   );
endinterface

`default_nettype wire

/* hdl/cfb_crc_unit.sv */
// ----------------------------------------------------------------------------
// cfb_crc_unit: CRC-8 accumulator
// Folds one byte per cycle into the running CRC while update is set; cleared at frame start.
// ----------------------------------------------------------------------------
`default_nettype none

module cfb_crc_unit
   import cfb_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire crc_ctrl_type ctrl,
   output logic [7:0]        crc
);

   logic [7:0] crc_ff;
   logic [7:0] crc_in;

   always_comb begin
      crc_in = crc_ff;
      if (ctrl.clear) begin
         crc_in = 8'd0;
      end else if (ctrl.update) begin
         crc_in = crc8_byte(crc_ff, ctrl.data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= 8'd0;
      end else begin
         crc_ff <= crc_in;
      end
   end

   assign crc = crc_ff;

endmodule

`default_nettype wire

/* hdl/cfb_sequencer.sv */
// ----------------------------------------------------------------------------
// cfb_sequencer: frame sequencer
// Holds the request, walks the frame byte by byte and steers the CRC unit.
// ----------------------------------------------------------------------------
`default_nettype none

module cfb_sequencer
   import cfb_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         accept,
   input  wire req_type      req,
   input  wire logic         slot_free,
   input  wire logic [7:0]   crc,
   output logic              busy,
   output logic              emit,
   output logic [7:0]        emit_byte,
   output logic              emit_last,
   output crc_ctrl_type      crc_ctrl
);

   seq_state_type        state_ff, state_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [7:0]           axis_ff, axis_in;
   logic [7:0]           command_ff, command_in;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic [PAYLOAD_W-1:0] payload_ff, payload_in;
   logic [LEN_W-1:0]     len_sat;
   logic                 is_crc;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         pos_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      axis_ff    <= axis_in;
      command_ff <= command_in;
      len_ff     <= len_in;
      payload_ff <= payload_in;
   end

   always_comb begin
      // saturate oversized lengths
      if (req.payload_len > LEN_W'(MAX_PAYLOAD)) begin
         len_sat = LEN_W'(MAX_PAYLOAD);
      end else begin
         len_sat = req.payload_len;
      end

      is_crc = ({1'b0, pos_ff} == (POS_W + 1)'(HDR_BYTES + 32'(len_ff)));

      case (pos_ff)
         POS_PREFIX: emit_byte = FRAME_PREFIX;
         POS_SYNC:   emit_byte = FRAME_SYNC;
         POS_LEN:    emit_byte = LEN_OVERHEAD + 8'(len_ff);
         POS_AXIS:   emit_byte = axis_ff;
         POS_CMD:    emit_byte = command_ff;
         default: begin
            if (is_crc) begin
               emit_byte = crc;
            end else begin
               emit_byte = payload_ff[7:0];
            end
         end
      endcase

      state_in   = state_ff;
      pos_in     = pos_ff;
      axis_in    = axis_ff;
      command_in = command_ff;
      len_in     = len_ff;
      payload_in = payload_ff;
      busy       = (state_ff == SEQ_SEND);
      emit       = 1'b0;
      emit_last  = 1'b0;
      crc_ctrl   = '{clear: 1'b0, update: 1'b0, data: emit_byte};

      case (state_ff)
         SEQ_IDLE: begin
            if (accept) begin
               axis_in         = req.axis;
               command_in      = req.command;
               len_in          = len_sat;
               payload_in      = req.payload_bytes;
               pos_in          = POS_PREFIX;
               crc_ctrl.clear  = 1'b1;
               state_in        = SEQ_SEND;
            end
         end
         SEQ_SEND: begin
            if (slot_free) begin
               emit            = 1'b1;
               emit_last       = is_crc;
               crc_ctrl.update = (pos_ff != POS_PREFIX) && !is_crc;
               pos_in          = pos_ff + POS_W'(1);
               // advance the payload after each payload byte
               if (pos_ff > POS_CMD && !is_crc) begin
                  payload_in = payload_ff >> 8;
               end
               if (is_crc) begin
                  state_in = SEQ_IDLE;
               end
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

/* hdl/command_frame_builder_crc8.sv */
// ----------------------------------------------------------------------------
// command_frame_builder_crc8: framed command packet encoder with CRC-8
// Turns one command request into a byte stream: prefix, sync, length, axis,
// command, payload bytes (low byte first) and a CRC-8 over sync..payload.
// ----------------------------------------------------------------------------
//
//   channel   | dir | beat contents                                 | handshake
//   ----------+-----+-----------------------------------------------+------------
//   req_bus   | in  | axis, command, payload_len, payload_bytes     | valid/ready
//   rsp_bus   | out | out_byte, last (set on the trailing CRC byte)  | valid/ready
//
// A request with n payload bytes (n saturated to 8) yields 6 + n byte beats.
// Without back-pressure a request is first captured, then one byte is sent
// per cycle, set by the CRC unit folding one byte a cycle and by the single
// output register.
// Synchronous active-high reset clears the sequencer and the output valid.
// A stalled rsp_bus holds the current byte and freezes the sequencer; req_bus
// is ready only while no frame is in progress.
// ----------------------------------------------------------------------------
`default_nettype none

module command_frame_builder_crc8
   import cfb_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   cfb_req_if.sink   req_bus,
   cfb_rsp_if.source rsp_bus
);

   logic         busy;
   logic         accept;
   logic         slot_free;
   logic         emit;
   logic [7:0]   emit_byte;
   logic         emit_last;
   logic [7:0]   crc;
   crc_ctrl_type crc_ctrl;
   req_type      req;

   logic         rsp_valid_ff, rsp_valid_in;
   logic [7:0]   out_byte_ff, out_byte_in;
   logic         last_ff, last_in;

   // take a request only between frames
   assign req_bus.ready = !busy;
   assign accept        = req_bus.valid && req_bus.ready;

   assign req = '{axis:          req_bus.axis,
                  command:       req_bus.command,
                  payload_len:   req_bus.payload_len,
                  payload_bytes: req_bus.payload_bytes};

   // the output register can take a byte when empty or being drained
   assign slot_free = !rsp_valid_ff || rsp_bus.ready;

   cfb_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req),
      .slot_free (slot_free),
      .crc       (crc),
      .busy      (busy),
      .emit      (emit),
      .emit_byte (emit_byte),
      .emit_last (emit_last),
      .crc_ctrl  (crc_ctrl)
   );

   cfb_crc_unit u_crc (
      .clock (clock),
      .reset (reset),
      .ctrl  (crc_ctrl),
      .crc   (crc)
   );

   // output register: load on emit, drop valid once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      out_byte_in  = out_byte_ff;
      last_in      = last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         out_byte_in  = emit_byte;
         last_in      = emit_last;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
      last_ff     <= last_in;
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.out_byte = out_byte_ff;
   assign rsp_bus.last     = last_ff;

`ifndef ASSERT_OFF
   a_accept_starts_frame: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy && !req_bus.ready)
      else $error("accepted request did not start a frame");

   a_last_ends_frame: assert property (@(posedge clock) disable iff (reset)
      emit && emit_last |=> !busy)
      else $error("sequencer still busy after the CRC byte");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_bus.ready |-> !emit)
      else $error("byte emitted into an occupied output register");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_bus.valid && !busy)
      else $error("reset left the block active");
`endif

endmodule

`default_nettype wire

/* verif/tb_command_frame_builder_crc8.sv */
// ----------------------------------------------------------------------------
// tb_command_frame_builder_crc8: self-checking bench for the CRC-8 frame builder
// Sends command requests on req_bus and predicts each frame byte by byte:
// prefix, sync, length, axis, command, payload, then the CRC-8. Every byte
// beat on rsp_bus is checked against the oldest predicted byte. Both channels
// idle and stall at random, except for one stretch with no idling.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_command_frame_builder_crc8
   import cfb_pkg::*;
   ;

   localparam int IDLE_PERCENT    = 26;
   localparam int RANDOM_REQUESTS = 202;
   localparam int STALL_LIMIT     = 2000;   // cycles with no beat on either channel
   localparam int SETTLE_CYCLES   = 20;
   localparam int BURST_FIRST     = 70;     // requests_sent range with no idling
   localparam int BURST_LAST      = 120;
   localparam int DRAIN_AT_A      = 40;     // hold the sender until all bytes are out
   localparam int DRAIN_AT_B      = 150;
   localparam int REPORT_LIMIT    = 10;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       is_last;
   } frame_beat_type;

   logic clock = 1'b0;
   logic reset;

   cfb_req_if req_bus ();
   cfb_rsp_if rsp_bus ();

   command_frame_builder_crc8 u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   req_type        pending_requests[$];
   frame_beat_type expected_frame_bytes[$];
   req_type        current_request;

   int requests_sent    = 0;
   int oversize_sent    = 0;
   int bytes_checked    = 0;
   int frames_checked   = 0;
   int mismatch_count   = 0;
   int quiet_cycles     = 0;
   int drain_pauses     = 0;

   // ------------------------------------------------------------------------
   // Clock
   // ------------------------------------------------------------------------
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Frame predictor
   // ------------------------------------------------------------------------

   // Fold one byte into the CRC, one bit at a time, MSB first.
   function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] acc;
      logic       feedback;
      acc = crc;
      for (int bit_idx = 7; bit_idx >= 0; bit_idx--) begin
         feedback = acc[7] ^ data[bit_idx];
         acc      = {acc[6:0], 1'b0} ^ (feedback ? CRC_POLY : 8'h00);
      end
      return acc;
   endfunction

   // Append one predicted byte to the tail of the expected bytes.
   task automatic expect_byte(input logic [7:0] frame_byte, input logic is_last);
      frame_beat_type beat;
      beat.frame_byte = frame_byte;
      beat.is_last    = is_last;
      expected_frame_bytes.insert(expected_frame_bytes.size(), beat);
   endtask

   // Append the whole frame for one accepted request to the expected bytes.
   // Lengths above the payload capacity saturate; unused bytes never appear.
   task automatic predict_frame(input req_type r);
      logic [7:0] frame_crc;
      logic [7:0] covered[$];
      int         used_len;
      used_len  = (r.payload_len > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(r.payload_len);
      frame_crc = 8'h00;
      covered   = {FRAME_SYNC, 8'(LEN_OVERHEAD + used_len), r.axis, r.command};
      for (int i = 0; i < used_len; i++) begin
         covered = {covered, r.payload_bytes[8*i +: 8]};
      end
      expect_byte(FRAME_PREFIX, 1'b0);
      foreach (covered[i]) begin
         frame_crc = crc8_fold(frame_crc, covered[i]);
         expect_byte(covered[i], 1'b0);
      end
      expect_byte(frame_crc, 1'b1);
   endtask

   task automatic queue_request(input logic [7:0] axis, input logic [7:0] command,
                                input logic [LEN_W-1:0] len,
                                input logic [PAYLOAD_W-1:0] payload);
      req_type r;
      r.axis          = axis;
      r.command       = command;
      r.payload_len   = len;
      r.payload_bytes = payload;
      pending_requests.insert(pending_requests.size(), r);
   endtask

   function automatic bit in_burst();
      return requests_sent >= BURST_FIRST && requests_sent < BURST_LAST;
   endfunction

   // ------------------------------------------------------------------------
   // Request driver: advance to the next pending request after each accepted
   // beat, idle at random, and hold at the drain points until the frame
   // store is empty.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid         <= 1'b0;
         req_bus.axis          <= '0;
         req_bus.command       <= '0;
         req_bus.payload_len   <= '0;
         req_bus.payload_bytes <= '0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predict_frame(current_request);
            requests_sent++;
            if (current_request.payload_len > MAX_PAYLOAD) begin
               oversize_sent++;
            end
            if (requests_sent == DRAIN_AT_A || requests_sent == DRAIN_AT_B) begin
               drain_pauses++;
            end
         end
         // A beat still waiting for ready stays as it is.
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_requests.size() != 0
                && !((requests_sent == DRAIN_AT_A || requests_sent == DRAIN_AT_B)
                     && expected_frame_bytes.size() != 0)
                && (in_burst() || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
               current_request             = pending_requests.pop_front();
               req_bus.valid              <= 1'b1;
               req_bus.axis               <= current_request.axis;
               req_bus.command            <= current_request.command;
               req_bus.payload_len        <= current_request.payload_len;
               req_bus.payload_bytes      <= current_request.payload_bytes;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Byte monitor: stall at random and check every byte beat against the
   // oldest predicted byte. Keep counting after the first mismatch.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_frame_bytes.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("ERROR: unexpected byte beat out_byte=%02h last=%0b",
                           rsp_bus.out_byte, rsp_bus.last);
               end
            end else begin
               frame_beat_type want;
               want = expected_frame_bytes.pop_front();
               bytes_checked++;
               if (want.is_last) begin
                  frames_checked++;
               end
               if (rsp_bus.out_byte !== want.frame_byte || rsp_bus.last !== want.is_last) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT) begin
                     $display("ERROR: byte %0d: expected %02h last=%0b, got %02h last=%0b",
                              bytes_checked, want.frame_byte, want.is_last,
                              rsp_bus.out_byte, rsp_bus.last);
                  end
               end
            end
         end
         rsp_bus.ready <= in_burst() || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog: end the run if neither channel moves a beat for too long.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("ERROR: no beat for %0d cycles, %0d bytes still expected",
                     STALL_LIMIT, expected_frame_bytes.size());
            $display("Verification failed");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus and end of run
   // ------------------------------------------------------------------------
   initial begin
      logic [LEN_W-1:0] len;
      reset = 1'b1;

      // Directed: bare command, all-ones, every used length, saturating
      // lengths and payload bytes beyond the used length.
      queue_request(8'h00, 8'h00, 4'd0, 64'h0);
      queue_request(8'hFF, 8'hFF, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF);
      queue_request(8'hFF, 8'hFF, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF);
      queue_request(8'h55, 8'hAA, 4'd8, 64'h0123_4567_89AB_CDEF);
      queue_request(8'hAA, 8'h55, 4'd8, 64'h0);
      for (int n = 1; n <= 7; n++) begin
         queue_request(8'(n), 8'(8'h10 + n), LEN_W'(n), {$urandom(), $urandom()});
      end
      queue_request(8'h01, 8'h80, 4'd9, 64'hA5A5_A5A5_A5A5_A5A5);
      queue_request(8'h80, 8'h01, 4'd12, 64'h8000_0000_0000_0001);
      queue_request(8'h7F, 8'hFE, 4'd15, 64'hFEDC_BA98_7654_3210);
      // Upper bytes set but unused.
      queue_request(8'h33, 8'hCC, 4'd3, 64'hFFFF_FFFF_FF12_3456);
      queue_request(8'h06, 8'hAA, 4'd1, 64'hFFFF_FFFF_FFFF_FF00);
      queue_request(8'h00, 8'h31, 4'd2, 64'h0000_0000_0000_AA06);

      // Random: mostly legal lengths, some that saturate.
      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         if ($urandom_range(0, 99) < 10) begin
            len = LEN_W'($urandom_range(MAX_PAYLOAD + 1, 15));
         end else begin
            len = LEN_W'($urandom_range(0, MAX_PAYLOAD));
         end
         queue_request(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), len,
                       {$urandom(), $urandom()});
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Drain the sender, then the frame store, then let the block settle.
      while (pending_requests.size() != 0 || req_bus.valid) @(posedge clock);
      while (expected_frame_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d requests (%0d with saturating length), %0d drain pauses",
               requests_sent, oversize_sent, drain_pauses);
      $display("Checked %0d frames, %0d bytes, %0d mismatches",
               frames_checked, bytes_checked, mismatch_count);
      if (mismatch_count == 0 && expected_frame_bytes.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
